/* rtl/qrv_pkg.sv */
package qrv_pkg;

   // Rotation matrix entries, units of 2^-27
   typedef logic signed [32:0] h_type;

   // One matrix column, feeds one output lane
   typedef struct packed {
      h_type r1;
      h_type r2;
      h_type r3;
   } h_col_type;

   // Load enables of the lane pipeline stages
   typedef struct packed {
      logic s3;
      logic s4;
      logic s5;
   } pipe_load_type;

   // 1.0 in units of 2^-27
   localparam h_type H_ONE = 33'sd134217728;

   // Register reset values
   localparam logic signed [15:0] QUAT_W_RESET = 16'sd16384;
   localparam logic signed [15:0] QUAT_V_RESET = 16'sd0;
   localparam logic [15:0]        TOL_RESET    = 16'd65;

   // Register indexes
   localparam logic [2:0] REG_QUAT_W   = 3'd0;
   localparam logic [2:0] REG_QUAT_X   = 3'd1;
   localparam logic [2:0] REG_QUAT_Y   = 3'd2;
   localparam logic [2:0] REG_QUAT_Z   = 3'd3;
   localparam logic [2:0] REG_ZERO_TOL = 3'd4;

   // Saturation bounds
   localparam logic signed [31:0] RES_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] RES_MIN = 32'sh80000000;

endpackage

/* rtl/qrv_matrix.sv */
module qrv_matrix (
   input  logic                  clock,
   input  logic                  reset,
   input  logic signed [15:0]    quat_w,
   input  logic signed [15:0]    quat_x,
   input  logic signed [15:0]    quat_y,
   input  logic signed [15:0]    quat_z,
   output qrv_pkg::h_col_type    col_x,
   output qrv_pkg::h_col_type    col_y,
   output qrv_pkg::h_col_type    col_z
);
   import qrv_pkg::*;

   logic signed [31:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   h_type h11_ff, h12_ff, h13_ff, h21_ff, h22_ff, h23_ff, h31_ff, h32_ff, h33_ff;

   // Pairwise quaternion products, exact Q3.28
   always_ff @(posedge clock) begin
      if (reset) begin
         xx_ff <= '0; yy_ff <= '0; zz_ff <= '0;
         xy_ff <= '0; xz_ff <= '0; yz_ff <= '0;
         wx_ff <= '0; wy_ff <= '0; wz_ff <= '0;
      end else begin
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         zz_ff <= quat_z * quat_z;
         xy_ff <= quat_x * quat_y;
         xz_ff <= quat_x * quat_z;
         yz_ff <= quat_y * quat_z;
         wx_ff <= quat_w * quat_x;
         wy_ff <= quat_w * quat_y;
         wz_ff <= quat_w * quat_z;
      end
   end

   // Entries of the unit-quaternion matrix; identity out of reset
   always_ff @(posedge clock) begin
      if (reset) begin
         h11_ff <= H_ONE; h12_ff <= '0;    h13_ff <= '0;
         h21_ff <= '0;    h22_ff <= H_ONE; h23_ff <= '0;
         h31_ff <= '0;    h32_ff <= '0;    h33_ff <= H_ONE;
      end else begin
         h11_ff <= H_ONE - (33'(yy_ff) + 33'(zz_ff));
         h12_ff <= 33'(xy_ff) + 33'(wz_ff);
         h13_ff <= 33'(xz_ff) - 33'(wy_ff);
         h21_ff <= 33'(xy_ff) - 33'(wz_ff);
         h22_ff <= H_ONE - (33'(xx_ff) + 33'(zz_ff));
         h23_ff <= 33'(yz_ff) + 33'(wx_ff);
         h31_ff <= 33'(xz_ff) + 33'(wy_ff);
         h32_ff <= 33'(yz_ff) - 33'(wx_ff);
         h33_ff <= H_ONE - (33'(xx_ff) + 33'(yy_ff));
      end
   end

   // Columns: row vector times matrix
   assign col_x = '{r1: h11_ff, r2: h21_ff, r3: h31_ff};
   assign col_y = '{r1: h12_ff, r2: h22_ff, r3: h32_ff};
   assign col_z = '{r1: h13_ff, r2: h23_ff, r3: h33_ff};

endmodule

/* rtl/qrv_lane.sv */
module qrv_lane (
   input  logic                     clock,
   input  qrv_pkg::pipe_load_type   load,
   input  logic signed [31:0]       vec_a,
   input  logic signed [31:0]       vec_b,
   input  logic signed [31:0]       vec_c,
   input  qrv_pkg::h_col_type       col,
   input  logic [15:0]              tol,
   output logic signed [31:0]       result
);
   import qrv_pkg::*;

   logic signed [31:0] vec [3];
   h_type              h   [3];

   logic signed [48:0] pp_hi_ff [3];
   logic signed [49:0] pp_lo_ff [3];
   logic signed [50:0] s_hi_ff;
   logic signed [51:0] s_lo_ff;
   logic signed [40:0] r_ff;

   logic signed [51:0] lo_r;
   logic signed [51:0] carry;
   logic signed [51:0] sum_in;
   logic signed [31:0] sat;
   logic signed [32:0] sat_ext;
   logic signed [32:0] mag;
   logic               fits;

   assign vec[0] = vec_a;
   assign vec[1] = vec_b;
   assign vec[2] = vec_c;
   assign h[0]   = col.r1;
   assign h[1]   = col.r2;
   assign h[2]   = col.r3;

   // Stage 3: split each component in 16-bit halves, multiply by the entry
   always_ff @(posedge clock) begin
      if (load.s3) begin
         for (int j = 0; j < 3; j++) begin
            pp_hi_ff[j] <= $signed(vec[j][31:16]) * h[j];
            pp_lo_ff[j] <= $signed({1'b0, vec[j][15:0]}) * h[j];
         end
      end
   end

   // Stage 4: sum the high and low partial products
   always_ff @(posedge clock) begin
      if (load.s4) begin
         s_hi_ff <= 51'(pp_hi_ff[0]) + 51'(pp_hi_ff[1]) + 51'(pp_hi_ff[2]);
         s_lo_ff <= 52'(pp_lo_ff[0]) + 52'(pp_lo_ff[1]) + 52'(pp_lo_ff[2]);
      end
   end

   // Stage 5: round half up to 2^-16 and recombine
   assign lo_r   = s_lo_ff + 52'sd67108864;
   assign carry  = lo_r >>> 16;
   assign sum_in = 52'(s_hi_ff) + carry;

   always_ff @(posedge clock) begin
      if (load.s5) begin
         r_ff <= sum_in[51:11];
      end
   end

   // Saturate, then snap small magnitudes to zero
   assign fits    = (r_ff[40:31] == {10{r_ff[31]}});
   assign sat     = fits ? r_ff[31:0] : (r_ff[40] ? RES_MIN : RES_MAX);
   assign sat_ext = 33'(sat);
   assign mag     = sat[31] ? -sat_ext : sat_ext;
   assign result  = ($unsigned(mag) <= 33'(tol)) ? 32'sd0 : sat;

endmodule

/* rtl/quaternion_rotate_vector_core.sv */
// Rotates a Q16.16 vector (req_in_x/y/z) by the quaternion held in the CSRs
// (quat_w/x/y/z in Q1.14 at byte addresses 0x0..0xC, zero_tolerance at 0x10)
// and returns the rotated vector on rsp_out_x/y/z. The matrix is built from
// the quaternion as it stands, with no normalization. Each component is
// rounded half up, saturated to 32 bits, then forced to zero when its
// magnitude is at most zero_tolerance. One beat is taken every clock while
// req_stall is low; rsp_valid rises as it reaches the output of the six-stage
// pipeline (input, align, partial products, sums, rounding, output), whose
// first stage loads at the accepting edge. req_stall rises only when all six
// stages hold beats and rsp_stall is high. Three lanes, one per output
// component, run side by side. The matrix lags a CSR write, which the input and
// align stages cover, so a beat may be accepted at any edge after the write.
module quaternion_rotate_vector_core (
   input  logic                clock,
   input  logic                reset,
   // input channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_in_x,
   input  logic signed [31:0]  req_in_y,
   input  logic signed [31:0]  req_in_z,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_out_x,
   output logic signed [31:0]  rsp_out_y,
   output logic signed [31:0]  rsp_out_z,
   // CSR port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import qrv_pkg::*;

   logic signed [15:0] quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   logic [15:0]        tol_ff;
   logic [2:0]         reg_idx;
   logic               csr_wr;

   h_col_type          col_x, col_y, col_z;
   pipe_load_type      lane_load;

   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic               ld1, ld2, ld3, ld4, ld5, ld6;
   logic signed [31:0] x1_ff, y1_ff, z1_ff;
   logic signed [31:0] x2_ff, y2_ff, z2_ff;
   logic signed [31:0] res_x, res_y, res_z;

   // CSR decode
   assign reg_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_w_ff <= QUAT_W_RESET;
         quat_x_ff <= QUAT_V_RESET;
         quat_y_ff <= QUAT_V_RESET;
         quat_z_ff <= QUAT_V_RESET;
         tol_ff    <= TOL_RESET;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_QUAT_W:   quat_w_ff <= csr_pwdata[15:0];
            REG_QUAT_X:   quat_x_ff <= csr_pwdata[15:0];
            REG_QUAT_Y:   quat_y_ff <= csr_pwdata[15:0];
            REG_QUAT_Z:   quat_z_ff <= csr_pwdata[15:0];
            REG_ZERO_TOL: tol_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_QUAT_W:   csr_prdata = 32'(quat_w_ff);
         REG_QUAT_X:   csr_prdata = 32'(quat_x_ff);
         REG_QUAT_Y:   csr_prdata = 32'(quat_y_ff);
         REG_QUAT_Z:   csr_prdata = 32'(quat_z_ff);
         REG_ZERO_TOL: csr_prdata = {16'd0, tol_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // Matrix from the quaternion
   qrv_matrix u_matrix (
      .clock  (clock),
      .reset  (reset),
      .quat_w (quat_w_ff),
      .quat_x (quat_x_ff),
      .quat_y (quat_y_ff),
      .quat_z (quat_z_ff),
      .col_x  (col_x),
      .col_y  (col_y),
      .col_z  (col_z)
   );

   // Stage loads: a stage takes new data when empty or when it moves on
   assign ld6 = !v6_ff || !rsp_stall;
   assign ld5 = !v5_ff || ld6;
   assign ld4 = !v4_ff || ld5;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign req_stall = !ld1;
   assign lane_load = '{s3: ld3, s4: ld4, s5: ld5};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= req_valid;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
         if (ld5) v5_ff <= v4_ff;
         if (ld6) v6_ff <= v5_ff;
      end
   end

   // Input beat and alignment stage
   always_ff @(posedge clock) begin
      if (ld1) begin
         x1_ff <= req_in_x;
         y1_ff <= req_in_y;
         z1_ff <= req_in_z;
      end
      if (ld2) begin
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         z2_ff <= z1_ff;
      end
   end

   // One lane per output component
   qrv_lane u_lane_x (
      .clock (clock), .load (lane_load),
      .vec_a (x2_ff), .vec_b (y2_ff), .vec_c (z2_ff),
      .col (col_x), .tol (tol_ff), .result (res_x)
   );

   qrv_lane u_lane_y (
      .clock (clock), .load (lane_load),
      .vec_a (x2_ff), .vec_b (y2_ff), .vec_c (z2_ff),
      .col (col_y), .tol (tol_ff), .result (res_y)
   );

   qrv_lane u_lane_z (
      .clock (clock), .load (lane_load),
      .vec_a (x2_ff), .vec_b (y2_ff), .vec_c (z2_ff),
      .col (col_z), .tol (tol_ff), .result (res_z)
   );

   // Merge the lanes into the output register
   always_ff @(posedge clock) begin
      if (ld6) begin
         rsp_out_x <= res_x;
         rsp_out_y <= res_y;
         rsp_out_z <= res_z;
      end
   end

   assign rsp_valid = v6_ff;

endmodule
